>>> rtl/fbfl_pkg.sv
// fbfl_pkg: types, sizes and codes of the fixed-size block free-list allocator
// no dependencies; used by the channel interfaces and the allocator top level
`default_nettype none

package fbfl_pkg;

  // pool size and widths
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       status_t;

  localparam cnt_t CNT_MAX  = {CNT_W{1'b1}};
  localparam cnt_t BC_LIMIT = CNT_W'(NUM_BLOCKS);

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  // one link entry: next block on the freed stack and whether it exists
  typedef struct packed {
    logic valid;
    idx_t next;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/fbfl_if.sv
// fbfl_if: valid/ready channel interfaces for requests, responses and config
// depends on fbfl_pkg for field types
`default_nettype none

interface fbfl_req_if;
  logic          valid;
  logic          ready;
  logic          command;
  fbfl_pkg::idx_t free_index;
  modport source (output valid, output command, output free_index, input ready);
  modport sink   (input valid, input command, input free_index, output ready);
endinterface

interface fbfl_rsp_if;
  logic              valid;
  logic              ready;
  fbfl_pkg::idx_t    granted_index;
  fbfl_pkg::status_t status;
  fbfl_pkg::cnt_t    blocks_free;
  modport source (output valid, output granted_index, output status, output blocks_free,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input blocks_free,
                  output ready);
endinterface

interface fbfl_cfg_if;
  logic           valid;
  logic           ready;
  fbfl_pkg::cnt_t block_count;
  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

`default_nettype wire

>>> rtl/fixed_block_free_list_allocator.sv
// fixed_block_free_list_allocator: LIFO free-list allocator over a pool of equal blocks
// depends on fbfl_pkg and the channel interfaces in fbfl_if.sv
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+------------------------------------------
//   cfg     | in  | valid/ready  | block_count (pool size, reinits list)
//   req     | in  | valid/ready  | command, free_index
//   rsp     | out | valid/ready  | granted_index, status, blocks_free
//
// a free, a watermark allocate or a failed request loads the response directly; a pop
// waits in ST_POP for the registered read of the link memory that yields the new head
// rst (synchronous) restores block_count 1024 and an empty freed stack; the link
// memory is not cleared, only entries written by a free are ever read
// a response held in the output register by rsp.ready low blocks the next item;
// a block count write waits for idle and goes ahead of a waiting request
`default_nettype none

module fixed_block_free_list_allocator (
  input  wire        clk,
  input  wire        rst,
  fbfl_cfg_if.sink   cfg,
  fbfl_req_if.sink   req,
  fbfl_rsp_if.source rsp
);
  import fbfl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic    state;
  // list control
  cnt_t    block_count;
  cnt_t    free_total;
  cnt_t    mark;
  idx_t    head;
  logic    head_valid;
  // output register
  logic    out_valid;
  idx_t    out_index;
  status_t out_status;
  cnt_t    out_free;
  // link memory and its registered read port
  link_t   link_mem [NUM_BLOCKS];
  link_t   rd_link;

  logic    req_acc;
  logic    cfg_acc;
  logic    is_alloc;
  logic    in_range;
  logic    pop_issue;
  logic    push;
  logic    out_load;
  cnt_t    free_dec;
  cnt_t    free_inc;
  cnt_t    cfg_clamped;

  // new items only while idle, with room in the output register and no config write
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready) && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;

  assign is_alloc  = (req.command == CMD_ALLOC);
  assign in_range  = {1'b0, req.free_index} < block_count;
  // allocate with a freed block on the stack needs the link read
  assign pop_issue = req_acc && is_alloc && head_valid;
  assign push      = req_acc && !is_alloc && in_range;
  // a response is loaded for every item but a pop, which loads in the cycle after, from ST_POP
  assign out_load  = (req_acc && !pop_issue) || (state == ST_POP);

  // free count saturates at both ends
  assign free_dec    = (free_total != '0) ? free_total - 1'b1 : free_total;
  assign free_inc    = (free_total != CNT_MAX) ? free_total + 1'b1 : free_total;
  assign cfg_clamped = (cfg.block_count > BC_LIMIT) ? BC_LIMIT : cfg.block_count;

  // link memory: written by a free, read at the head by a pop
  always_ff @(posedge clk) begin
    if (push) begin
      link_mem[req.free_index] <= '{valid: head_valid, next: head};
    end
    if (pop_issue) begin
      rd_link <= link_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      block_count <= BC_LIMIT;
      free_total  <= BC_LIMIT;
      mark        <= '0;
      head        <= '0;
      head_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      // config arrives only while idle: rebuild the list lazily
      if (cfg_acc) begin
        block_count <= cfg_clamped;
        free_total  <= cfg_clamped;
        mark        <= '0;
        head_valid  <= 1'b0;
        head        <= '0;
      end

      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            if (is_alloc) begin
              if (head_valid) begin
                // response comes once the link is back
                state <= ST_POP;
              end else if (mark < block_count) begin
                // fresh block from the watermark
                mark       <= mark + 1'b1;
                free_total <= free_dec;
                out_index  <= mark[IDX_W-1:0];
                out_status <= STATUS_OK;
                out_free   <= free_dec;
              end else begin
                out_index  <= '0;
                out_status <= STATUS_EMPTY;
                out_free   <= free_total;
              end
            end else if (in_range) begin
              // push onto the freed stack
              head       <= req.free_index;
              head_valid <= 1'b1;
              free_total <= free_inc;
              out_index  <= '0;
              out_status <= STATUS_OK;
              out_free   <= free_inc;
            end else begin
              out_index  <= '0;
              out_status <= STATUS_RANGE;
              out_free   <= free_total;
            end
          end
        end
        ST_POP: begin
          // hand out the old head, follow its link
          head       <= rd_link.next;
          head_valid <= rd_link.valid;
          free_total <= free_dec;
          out_index  <= head;
          out_status <= STATUS_OK;
          out_free   <= free_dec;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.granted_index = out_index;
  assign rsp.status        = out_status;
  assign rsp.blocks_free   = out_free;

  // the pop wait returns to idle in the next cycle and ends in a response
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (state == ST_IDLE) && rsp.valid)
    else $error("pop wait did not finish in one cycle");

  // no new item while a pop is still resolving the head
  a_pop_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !req.ready)
    else $error("request taken during pop");

  // the watermark never passes the pool size
  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    mark <= block_count)
    else $error("watermark beyond block count");

  // a pop only starts with a valid stack head
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && $past(!rst) ##1 (state == ST_POP) |-> $past(head_valid))
    else $error("pop without a stack head");

endmodule

`default_nettype wire

>>> test/tb_fixed_block_free_list_allocator.sv
// testbench for fixed_block_free_list_allocator: directed table, random phases, pool drain
// depends on fbfl_pkg, the channel interfaces in fbfl_if.sv and the allocator top level
module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the block
  localparam int QUIET_CYCLES = 4;    // margin after the last response, covers a pop's wait
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 60;
  localparam int MAX_REPORTS  = 100;
  localparam int LAST_POOL    = 48;   // small pool for the closing drain
  localparam int LAST_FREES   = 40;

  // one response as the block should produce it
  typedef struct packed {
    idx_t    granted;
    status_t status;
    cnt_t    free_cnt;
  } outcome_t;

  // per offered item: use a hand-written expectation instead of the predictor
  typedef struct packed {
    logic     typed;
    outcome_t value;
  } override_t;

  typedef enum logic { ROW_SIZE, ROW_REQ } row_kind_t;

  // directed row: a block count write, or a request with an optional fixed answer
  typedef struct packed {
    row_kind_t kind;
    cnt_t      arg;    // block count, or free index on a request
    logic      cmd;
    logic      typed;
    outcome_t  want;
  } drill_row_t;

  logic clk;
  logic rst;

  fbfl_cfg_if cfg_ch ();
  fbfl_req_if req_ch ();
  fbfl_rsp_if rsp_ch ();

  fixed_block_free_list_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state: freed stack links, stack head, watermark, free count, pool size
  link_t chain [NUM_BLOCKS];
  idx_t  stack_top;
  logic  stack_live;
  cnt_t  fresh_mark;
  cnt_t  pool_size;
  cnt_t  free_cnt;

  outcome_t  pending_outcomes [$];
  override_t typed_q [$];

  int   mismatches = 0;
  int   cycles     = 0;
  int   idle_odds  = 4;     // 0: no idling, else one chance in idle_odds per item
  logic hold_rsp   = 1'b0;  // asks the receiver for one long hold-off

  // directed part; fixed answers only where they follow at a glance
  drill_row_t drill [26] = '{
    // fresh pool of 1024 after reset: watermark hands out 0, 1
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_OK,    11'd1023}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd1,    STATUS_OK,    11'd1022}},
    // top index freed and popped straight back
    '{ROW_REQ,  11'd1023, CMD_FREE,  1'b1, '{10'd0,    STATUS_OK,    11'd1023}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd1023, STATUS_OK,    11'd1022}},
    // double free of block 0, not detected, count grows
    '{ROW_REQ,  11'd0,    CMD_FREE,  1'b1, '{10'd0,    STATUS_OK,    11'd1023}},
    '{ROW_REQ,  11'd0,    CMD_FREE,  1'b1, '{10'd0,    STATUS_OK,    11'd1024}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_OK,    11'd1023}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_OK,    11'd1022}},
    // self-linked head keeps handing out block 0
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b0, '0},
    // all-ones count clamps to the pool size
    '{ROW_SIZE, 11'd2047, CMD_ALLOC, 1'b0, '0},
    '{ROW_REQ,  11'd1023, CMD_FREE,  1'b1, '{10'd0,    STATUS_OK,    11'd1025}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd1023, STATUS_OK,    11'd1024}},
    // zero blocks: every allocate empty, every free out of range
    '{ROW_SIZE, 11'd0,    CMD_ALLOC, 1'b0, '0},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_EMPTY, 11'd0}},
    '{ROW_REQ,  11'd0,    CMD_FREE,  1'b1, '{10'd0,    STATUS_RANGE, 11'd0}},
    '{ROW_REQ,  11'd1023, CMD_FREE,  1'b1, '{10'd0,    STATUS_RANGE, 11'd0}},
    // single block: exhaust, range edge, refill
    '{ROW_SIZE, 11'd1,    CMD_ALLOC, 1'b0, '0},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_OK,    11'd0}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_EMPTY, 11'd0}},
    '{ROW_REQ,  11'd1,    CMD_FREE,  1'b1, '{10'd0,    STATUS_RANGE, 11'd0}},
    '{ROW_REQ,  11'd0,    CMD_FREE,  1'b1, '{10'd0,    STATUS_OK,    11'd1}},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b1, '{10'd0,    STATUS_OK,    11'd0}},
    // rewrite of the reset value starts the list over
    '{ROW_SIZE, 11'd1024, CMD_ALLOC, 1'b0, '0},
    '{ROW_REQ,  11'd512,  CMD_FREE,  1'b0, '0},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b0, '0},
    '{ROW_REQ,  11'd0,    CMD_ALLOC, 1'b0, '0}
  };

  // block count write: clamp, empty freed stack, watermark back to zero
  function automatic void resize_pool(cnt_t v);
    pool_size  = (v > BC_LIMIT) ? BC_LIMIT : v;
    stack_live = 1'b0;
    stack_top  = '0;
    fresh_mark = '0;
    free_cnt   = pool_size;
  endfunction

  // one request against the predicted pool; returns the response it should give
  function automatic outcome_t pool_outcome(logic cmd, idx_t idx);
    outcome_t r;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (stack_live) begin
        // pop the freed stack first
        r.granted  = stack_top;
        stack_live = chain[stack_top].valid;
        stack_top  = chain[stack_top].next;
        if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
      end else if (fresh_mark < pool_size) begin
        // then untouched blocks in ascending order
        r.granted  = idx_t'(fresh_mark);
        fresh_mark = fresh_mark + 1'b1;
        if (free_cnt != '0) free_cnt = free_cnt - 1'b1;
      end else begin
        r.status = STATUS_EMPTY;
      end
    end else if (cnt_t'(idx) >= pool_size) begin
      r.status = STATUS_RANGE;
    end else begin
      // push on the head, count saturates
      chain[idx].valid = stack_live;
      chain[idx].next  = stack_top;
      stack_top        = idx;
      stack_live       = 1'b1;
      if (free_cnt != CNT_MAX) free_cnt = free_cnt + 1'b1;
    end
    r.free_cnt = free_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // offer one item and hold it until accepted, then maybe leave a gap
  task automatic offer_request(input logic cmd, input idx_t idx, input logic typed,
                               input outcome_t want);
    override_t ov;
    ov = '{typed, want};
    typed_q.push_back(ov);
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.free_index <= idx;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every response is in and the block is quiet
  task automatic drain_outcomes();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(input cnt_t v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.block_count <= v;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a stuck handshake ends the run as a failure
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // all handshakes seen at the same edge, in a fixed order:
  // responses checked first, then config and requests fed to the predictor
  always @(posedge clk) begin : watch
    outcome_t  want;
    outcome_t  got;
    override_t ov;
    if (rst) begin
      resize_pool(BC_LIMIT);
    end else begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("response with no request outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_ch.granted_index !== want.granted)
            flag_mismatch($sformatf("granted_index %0d, expected %0d",
                                    rsp_ch.granted_index, want.granted));
          if (rsp_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
          if (rsp_ch.blocks_free !== want.free_cnt)
            flag_mismatch($sformatf("blocks_free %0d, expected %0d",
                                    rsp_ch.blocks_free, want.free_cnt));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready === 1'b1) resize_pool(cfg_ch.block_count);
      if (req_ch.valid && req_ch.ready === 1'b1) begin
        got = pool_outcome(req_ch.command, req_ch.free_index);
        ov  = typed_q.pop_front();
        pending_outcomes.push_back(ov.typed ? ov.value : got);
      end
    end
  end

  // response side: random stall bursts, one long hold-off on request
  initial begin : rsp_side
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    cnt_t size;
    int   span;
    int   alloc_pct;
    logic cmd;
    idx_t idx;

    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.block_count <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_ALLOC;
    req_ch.free_index  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (drill[i]) begin
      if (drill[i].kind == ROW_SIZE) begin
        drain_outcomes();
        write_block_count(drill[i].arg);
      end else begin
        offer_request(drill[i].cmd, idx_t'(drill[i].arg), drill[i].typed, drill[i].want);
      end
    end

    // random phases, each with its own pool size, mix and idling
    for (int p = 0; p < PHASES; p++) begin
      drain_outcomes();
      case (p % 4)
        0:       size = cnt_t'($urandom_range(1, 8));
        1:       size = cnt_t'($urandom_range(9, 64));
        2:       size = cnt_t'($urandom_range(0, 2047));
        default: size = BC_LIMIT;
      endcase
      write_block_count(size);
      span      = (size > BC_LIMIT) ? NUM_BLOCKS : int'(size);
      alloc_pct = $urandom_range(25, 75);
      idle_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
      // sender keeps offering while the receiver sits out a long stretch
      if (p == 4) begin
        idle_odds = 0;
        hold_rsp  = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        // mostly in-range frees, now and then any index
        if (span != 0 && $urandom_range(0, 9) != 0)
          idx = idx_t'($urandom_range(0, span - 1));
        else
          idx = idx_t'($urandom);
        offer_request(cmd, idx, 1'b0, '0);
      end
    end

    // last part, no idling: repeated frees push a small pool past its size,
    // then allocates drain it to zero and go on until the pool is empty
    idle_odds = 0;
    drain_outcomes();
    write_block_count(cnt_t'(LAST_POOL));
    repeat (LAST_FREES)
      offer_request(CMD_FREE, idx_t'($urandom_range(0, LAST_POOL - 1)), 1'b0, '0);
    repeat (LAST_POOL + LAST_FREES + 12)
      offer_request(CMD_ALLOC, idx_t'($urandom), 1'b0, '0);

    drain_outcomes();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
